// ===== rtl/acc_pkg.sv =====
// Package for the alarm clock controller: request/response types, codes and digit helpers.
`default_nettype none

package acc_pkg;

   // Event codes carried in the func field
   localparam logic [2:0] FUNC_TICK   = 3'd0;
   localparam logic [2:0] FUNC_MENU   = 3'd1;
   localparam logic [2:0] FUNC_SELECT = 3'd2;
   localparam logic [2:0] FUNC_UP     = 3'd3;
   localparam logic [2:0] FUNC_SERIAL = 3'd4;

   // Digit selected for editing
   localparam logic [1:0] DIGIT_UNITS = 2'd0;
   localparam logic [1:0] DIGIT_TENS  = 2'd1;
   localparam logic [1:0] DIGIT_HOUR  = 2'd2;

   // LED patterns
   localparam logic [5:0] LED_OFF  = 6'd0;
   localparam logic [5:0] LED_EDIT = 6'd8;
   localparam logic [5:0] LED_TENS = 6'd16;
   localparam logic [5:0] LED_HOUR = 6'd32;

   localparam logic [6:0] SEG_ZERO = 7'h40;

   localparam logic [4:0] HOUR_MAX   = 5'd23;
   localparam logic [5:0] MINUTE_MAX = 6'd59;
   localparam logic [5:0] SECOND_MAX = 6'd59;

   typedef enum logic [1:0] {
      MODE_RUN   = 2'd0,
      MODE_ALARM = 2'd1,
      MODE_TIME  = 2'd2
   } mode_type;

   typedef struct packed {
      logic [2:0] func;
      logic [4:0] set_hour;
      logic [5:0] set_minute;
   } req_type;

   typedef struct packed {
      logic [6:0] seg_hour_tens;
      logic [6:0] seg_hour_units;
      logic [6:0] seg_minute_tens;
      logic [6:0] seg_minute_units;
      logic [5:0] led_pattern;
      logic       alarm_fire;
   } rsp_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
   } hm_type;

   // Digit codes, left to right
   typedef logic [0:3][6:0] codes_type;

   function automatic logic [6:0] seg_code(input logic [3:0] digit);
      logic [6:0] code;
      case (digit)
         4'd0: code = 7'h40;
         4'd1: code = 7'h79;
         4'd2: code = 7'h24;
         4'd3: code = 7'h30;
         4'd4: code = 7'h19;
         4'd5: code = 7'h12;
         4'd6: code = 7'h02;
         4'd7: code = 7'h78;
         4'd8: code = 7'h00;
         4'd9: code = 7'h18;
         default: code = SEG_ZERO;
      endcase
      return code;
   endfunction

   // Tens digit of a value below 60
   function automatic logic [3:0] tens_of(input logic [5:0] v);
      logic [3:0] t;
      if (v >= 6'd50) t = 4'd5;
      else if (v >= 6'd40) t = 4'd4;
      else if (v >= 6'd30) t = 4'd3;
      else if (v >= 6'd20) t = 4'd2;
      else if (v >= 6'd10) t = 4'd1;
      else t = 4'd0;
      return t;
   endfunction

   function automatic logic [3:0] units_of(input logic [5:0] v);
      logic [5:0] base;
      logic [5:0] diff;
      case (tens_of(v))
         4'd1: base = 6'd10;
         4'd2: base = 6'd20;
         4'd3: base = 6'd30;
         4'd4: base = 6'd40;
         4'd5: base = 6'd50;
         default: base = 6'd0;
      endcase
      diff = v - base;
      return diff[3:0];
   endfunction

   function automatic codes_type show_hm(input hm_type t);
      codes_type  codes;
      logic [5:0] hx;
      hx = {1'b0, t.hour};
      codes[0] = seg_code(tens_of(hx));
      codes[1] = seg_code(units_of(hx));
      codes[2] = seg_code(tens_of(t.minute));
      codes[3] = seg_code(units_of(t.minute));
      return codes;
   endfunction

   // Up-button edit of the selected digit; index two (DIGIT_HOUR) or above edits the hour
   function automatic hm_type bump(input hm_type t, input logic [1:0] digit);
      hm_type r;
      r = t;
      case (digit)
         DIGIT_UNITS: begin
            // units wrap inside their tens
            if (units_of(t.minute) == 4'd9) r.minute = t.minute - 6'd9;
            else r.minute = t.minute + 6'd1;
         end
         DIGIT_TENS: begin
            if (t.minute >= 6'd50) r.minute = {2'b00, units_of(t.minute)};
            else r.minute = t.minute + 6'd10;
         end
         default: begin
            if (t.hour >= HOUR_MAX) r.hour = 5'd0;
            else r.hour = t.hour + 5'd1;
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/acc_in_stage.sv =====
// Input register stage for the alarm clock controller.
`default_nettype none

module acc_in_stage (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire acc_pkg::req_type req_data,
   input  wire logic            fwd_ready,
   output logic                 item_valid,
   output acc_pkg::req_type     item
);

   logic             valid_ff, valid_in;
   acc_pkg::req_type item_ff, item_in;

   assign req_stall = valid_ff && !fwd_ready;

   always_comb begin
      valid_in = req_stall ? 1'b1 : req_valid;
      item_in  = req_stall ? item_ff : req_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ===== rtl/acc_core.sv =====
// Clock state and per-request update logic for the alarm clock controller.
`default_nettype none

module acc_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire acc_pkg::req_type item,
   output acc_pkg::rsp_type      result
);

   logic [5:0]         sec_ff, sec_in;
   acc_pkg::hm_type    time_ff, time_in;
   acc_pkg::hm_type    aedit_ff, aedit_in;
   acc_pkg::hm_type    amatch_ff, amatch_in;
   acc_pkg::mode_type  mode_ff, mode_in;
   logic [1:0]         digit_ff, digit_in;
   acc_pkg::codes_type codes_ff, codes_in;
   logic [5:0]         led_ff, led_in;
   logic               fire;
   acc_pkg::hm_type    tick_time;
   acc_pkg::hm_type    serial_time;

   always_comb begin
      // time after a minute rollover
      tick_time = time_ff;
      if (time_ff.minute >= acc_pkg::MINUTE_MAX) begin
         tick_time.minute = 6'd0;
         if (time_ff.hour >= acc_pkg::HOUR_MAX) tick_time.hour = 5'd0;
         else tick_time.hour = time_ff.hour + 5'd1;
      end else begin
         tick_time.minute = time_ff.minute + 6'd1;
      end

      serial_time.hour   = (item.set_hour > acc_pkg::HOUR_MAX) ?
                           acc_pkg::HOUR_MAX : item.set_hour;
      serial_time.minute = (item.set_minute > acc_pkg::MINUTE_MAX) ?
                           acc_pkg::MINUTE_MAX : item.set_minute;
   end

   always_comb begin
      sec_in    = sec_ff;
      time_in   = time_ff;
      aedit_in  = aedit_ff;
      amatch_in = amatch_ff;
      mode_in   = mode_ff;
      digit_in  = digit_ff;
      codes_in  = codes_ff;
      led_in    = led_ff;
      fire      = 1'b0;

      case (item.func)
         acc_pkg::FUNC_TICK: begin
            if (sec_ff >= acc_pkg::SECOND_MAX) begin
               sec_in   = 6'd0;
               time_in  = tick_time;
               codes_in = acc_pkg::show_hm(tick_time);
               if (tick_time == amatch_ff) begin
                  fire   = 1'b1;
                  led_in = acc_pkg::LED_OFF;
               end
            end else begin
               sec_in = sec_ff + 6'd1;
            end
         end
         acc_pkg::FUNC_MENU: begin
            case (mode_ff)
               acc_pkg::MODE_RUN: begin
                  mode_in  = acc_pkg::MODE_ALARM;
                  codes_in = acc_pkg::show_hm(amatch_ff);
                  led_in   = acc_pkg::LED_EDIT;
               end
               acc_pkg::MODE_ALARM: begin
                  mode_in  = acc_pkg::MODE_TIME;
                  codes_in = acc_pkg::show_hm(time_ff);
                  led_in   = acc_pkg::LED_EDIT;
               end
               default: begin
                  // leaving time edit keeps the digits as they are
                  mode_in = acc_pkg::MODE_RUN;
                  led_in  = acc_pkg::LED_OFF;
               end
            endcase
         end
         acc_pkg::FUNC_SELECT: begin
            if (mode_ff != acc_pkg::MODE_RUN) begin
               case (digit_ff)
                  acc_pkg::DIGIT_UNITS: begin
                     digit_in = acc_pkg::DIGIT_TENS;
                     led_in   = acc_pkg::LED_TENS;
                  end
                  acc_pkg::DIGIT_TENS: begin
                     digit_in = acc_pkg::DIGIT_HOUR;
                     led_in   = acc_pkg::LED_HOUR;
                  end
                  default: begin
                     digit_in = acc_pkg::DIGIT_UNITS;
                     led_in   = acc_pkg::LED_EDIT;
                  end
               endcase
            end else begin
               led_in = acc_pkg::LED_OFF;
            end
         end
         acc_pkg::FUNC_UP: begin
            case (mode_ff)
               acc_pkg::MODE_TIME: begin
                  time_in  = acc_pkg::bump(time_ff, digit_ff);
                  sec_in   = 6'd0;
                  codes_in = acc_pkg::show_hm(time_in);
               end
               acc_pkg::MODE_ALARM: begin
                  aedit_in  = acc_pkg::bump(aedit_ff, digit_ff);
                  amatch_in = aedit_in;
                  codes_in  = acc_pkg::show_hm(aedit_in);
               end
               default: begin
               end
            endcase
         end
         acc_pkg::FUNC_SERIAL: begin
            amatch_in = serial_time;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff    <= 6'd0;
         time_ff   <= '0;
         aedit_ff  <= '0;
         amatch_ff <= '0;
         mode_ff   <= acc_pkg::MODE_RUN;
         digit_ff  <= acc_pkg::DIGIT_UNITS;
         codes_ff  <= {4{acc_pkg::SEG_ZERO}};
         led_ff    <= acc_pkg::LED_OFF;
      end else if (step) begin
         sec_ff    <= sec_in;
         time_ff   <= time_in;
         aedit_ff  <= aedit_in;
         amatch_ff <= amatch_in;
         mode_ff   <= mode_in;
         digit_ff  <= digit_in;
         codes_ff  <= codes_in;
         led_ff    <= led_in;
      end
   end

   always_comb begin
      result.seg_hour_tens    = codes_in[0];
      result.seg_hour_units   = codes_in[1];
      result.seg_minute_tens  = codes_in[2];
      result.seg_minute_units = codes_in[3];
      result.led_pattern      = led_in;
      result.alarm_fire       = fire;
   end

endmodule

`default_nettype wire

// ===== rtl/acc_out_stage.sv =====
// Output register stage for the alarm clock controller.
`default_nettype none

module acc_out_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load_valid,
   input  wire acc_pkg::rsp_type load_data,
   output logic                  ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output acc_pkg::rsp_type      rsp_data
);

   logic             valid_ff, valid_in;
   acc_pkg::rsp_type data_ff, data_in;

   assign ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = ready ? load_valid : valid_ff;
      data_in  = ready ? load_data : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/alarm_clock_controller.sv =====
// Top level of the 24-hour alarm clock controller.
// Each request carries one event in func: second tick, menu button, select
// button, up button or a serial alarm-time load (set_hour/set_minute).
// Each request yields exactly one response: the four active-low digit codes
// now on the display, the LED pattern and an alarm_fire flag that is
// set on the tick that rolls the clock onto the alarm minute.
// Channels use valid/stall; a transfer happens on a clock edge with valid high
// and stall low. A request is held in an input register while the clock state
// updates from it, and its response is loaded into the output register on the
// same edge as the state update; one request per cycle is sustained while
// rsp_stall is low. The state update is a single pass of small counter logic.
// When rsp_stall is high the response holds and the input register fills;
// req_stall then rises and stays high until the response is taken.
// Synchronous reset clears both stages, sets the time, alarm and mode to zero
// (run mode) and the display to all zero digits.
`default_nettype none

module alarm_clock_controller (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire acc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output acc_pkg::rsp_type      rsp_data
);

   logic             out_ready;
   logic             item_valid;
   acc_pkg::req_type item;
   logic             step;
   acc_pkg::rsp_type result;

   assign step = item_valid && out_ready;

   acc_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .fwd_ready  (out_ready),
      .item_valid (item_valid),
      .item       (item)
   );

   acc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item),
      .result (result)
   );

   acc_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load_valid (item_valid),
      .load_data  (result),
      .ready      (out_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/acc_checker.sv =====
// Port-level assertions for the alarm clock controller, bound to the top level.
`default_nettype none

module acc_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire acc_pkg::rsp_type rsp_data
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // requests back up only behind a stalled response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled response");

   a_fire_led: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.alarm_fire |-> rsp_data.led_pattern == acc_pkg::LED_OFF)
      else $error("alarm fired with LEDs lit");

   a_led_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.led_pattern == acc_pkg::LED_OFF
                 || rsp_data.led_pattern == acc_pkg::LED_EDIT
                 || rsp_data.led_pattern == acc_pkg::LED_TENS
                 || rsp_data.led_pattern == acc_pkg::LED_HOUR)
      else $error("LED pattern not a known code");

endmodule

bind alarm_clock_controller acc_checker u_acc_checker (.*);

`default_nettype wire

// ===== sim/alarm_clock_controller_tb.sv =====
// Self-checking testbench for the alarm clock controller: directed script, then random event streams.
`timescale 1ns / 1ps

module alarm_clock_controller_tb;

   localparam logic [2:0] FUNC_SPARE0 = 3'd5;
   localparam logic [2:0] FUNC_SPARE1 = 3'd6;
   localparam logic [2:0] FUNC_SPARE2 = 3'd7;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS = 280;
   localparam int SCRIPT_ROWS = 24;
   localparam int MINUTES_PER_DAY = 1440;
   localparam int MAX_REPORTS = 10;

   localparam acc_pkg::rsp_type ZERO_DISPLAY = {acc_pkg::SEG_ZERO, acc_pkg::SEG_ZERO,
      acc_pkg::SEG_ZERO, acc_pkg::SEG_ZERO, acc_pkg::LED_OFF, 1'b0};
   localparam acc_pkg::rsp_type ALARM_2359 = {7'h24, 7'h30, 7'h12, 7'h18,
      acc_pkg::LED_EDIT, 1'b0};
   localparam acc_pkg::rsp_type PREDICTED = '0;

   typedef struct packed {
      logic [2:0]       func;
      logic [4:0]       set_hour;
      logic [5:0]       set_minute;
      logic             typed;
      acc_pkg::rsp_type display;
   } script_row;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   acc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   acc_pkg::rsp_type rsp_data;

   int idle_pct = 0;
   int stall_pct = 0;
   int items_sent = 0;
   int errors = 0;
   int quiet_cycles = 0;
   acc_pkg::rsp_type expected_displays[$];
   script_row script [0:SCRIPT_ROWS-1];

   // clock state as the block should hold it
   int clk_sec = 0;
   int clk_min = 0;
   int clk_hour = 0;
   int alarm_edit_min = 0;
   int alarm_edit_hour = 0;
   int alarm_at = 0;
   acc_pkg::mode_type mode = acc_pkg::MODE_RUN;
   logic [1:0] digit = acc_pkg::DIGIT_UNITS;
   acc_pkg::codes_type shown = {4{acc_pkg::SEG_ZERO}};
   logic [5:0] led = acc_pkg::LED_OFF;

   alarm_clock_controller uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99, 0) < stall_pct);
   end

   function automatic logic [6:0] seg_for(input int d);
      logic [6:0] code;
      case (d)
         0: code = 7'h40;
         1: code = 7'h79;
         2: code = 7'h24;
         3: code = 7'h30;
         4: code = 7'h19;
         5: code = 7'h12;
         6: code = 7'h02;
         7: code = 7'h78;
         8: code = 7'h00;
         9: code = 7'h18;
         default: code = acc_pkg::SEG_ZERO;
      endcase
      return code;
   endfunction

   task automatic draw(input int h, input int m);
      shown[0] = seg_for(h / 10);
      shown[1] = seg_for(h % 10);
      shown[2] = seg_for(m / 10);
      shown[3] = seg_for(m % 10);
   endtask

   // up button on the selected digit; units wrap inside their tens
   task automatic step_digit(inout int mins, inout int hours);
      case (digit)
         acc_pkg::DIGIT_UNITS: begin
            mins = mins + 1;
            if (mins % 10 == 0) mins = mins - 10;
         end
         acc_pkg::DIGIT_TENS: begin
            mins = mins + 10;
            if (mins >= 60) mins = mins % 10;
         end
         default: begin
            hours = (hours >= acc_pkg::HOUR_MAX) ? 0 : hours + 1;
         end
      endcase
   endtask

   task automatic update_clock(input acc_pkg::req_type r, output acc_pkg::rsp_type want);
      int sh;
      int sm;
      logic fire;
      fire = 1'b0;
      case (r.func)
         acc_pkg::FUNC_TICK: begin
            clk_sec++;
            if (clk_sec > acc_pkg::SECOND_MAX) begin
               clk_sec = 0;
               clk_min++;
               if (clk_min > acc_pkg::MINUTE_MAX) begin
                  clk_min = 0;
                  clk_hour = (clk_hour >= acc_pkg::HOUR_MAX) ? 0 : clk_hour + 1;
               end
               draw(clk_hour, clk_min);
               if (clk_hour * 60 + clk_min == alarm_at) begin
                  fire = 1'b1;
                  led = acc_pkg::LED_OFF;
               end
            end
         end
         acc_pkg::FUNC_MENU: begin
            case (mode)
               acc_pkg::MODE_RUN: begin
                  mode = acc_pkg::MODE_ALARM;
                  draw(alarm_at / 60, alarm_at % 60);
                  led = acc_pkg::LED_EDIT;
               end
               acc_pkg::MODE_ALARM: begin
                  mode = acc_pkg::MODE_TIME;
                  draw(clk_hour, clk_min);
                  led = acc_pkg::LED_EDIT;
               end
               default: begin
                  // back to run without a redraw
                  mode = acc_pkg::MODE_RUN;
                  led = acc_pkg::LED_OFF;
               end
            endcase
         end
         acc_pkg::FUNC_SELECT: begin
            if (mode == acc_pkg::MODE_RUN) begin
               led = acc_pkg::LED_OFF;
            end else begin
               case (digit)
                  acc_pkg::DIGIT_UNITS: begin
                     digit = acc_pkg::DIGIT_TENS;
                     led = acc_pkg::LED_TENS;
                  end
                  acc_pkg::DIGIT_TENS: begin
                     digit = acc_pkg::DIGIT_HOUR;
                     led = acc_pkg::LED_HOUR;
                  end
                  default: begin
                     digit = acc_pkg::DIGIT_UNITS;
                     led = acc_pkg::LED_EDIT;
                  end
               endcase
            end
         end
         acc_pkg::FUNC_UP: begin
            if (mode == acc_pkg::MODE_TIME) begin
               step_digit(clk_min, clk_hour);
               clk_sec = 0;
               draw(clk_hour, clk_min);
            end else if (mode == acc_pkg::MODE_ALARM) begin
               step_digit(alarm_edit_min, alarm_edit_hour);
               alarm_at = alarm_edit_hour * 60 + alarm_edit_min;
               draw(alarm_at / 60, alarm_at % 60);
            end
         end
         acc_pkg::FUNC_SERIAL: begin
            sh = (r.set_hour > acc_pkg::HOUR_MAX) ? int'(acc_pkg::HOUR_MAX)
                                                  : int'(r.set_hour);
            sm = (r.set_minute > acc_pkg::MINUTE_MAX) ? int'(acc_pkg::MINUTE_MAX)
                                                      : int'(r.set_minute);
            alarm_at = sh * 60 + sm;
         end
         default: begin
         end
      endcase
      want.seg_hour_tens = shown[0];
      want.seg_hour_units = shown[1];
      want.seg_minute_tens = shown[2];
      want.seg_minute_units = shown[3];
      want.led_pattern = led;
      want.alarm_fire = fire;
   endtask

   task automatic send_event(input logic [2:0] f, input logic [4:0] sh, input logic [5:0] sm,
                             input logic typed, input acc_pkg::rsp_type given);
      acc_pkg::req_type r;
      acc_pkg::rsp_type want;
      r.func = f;
      r.set_hour = sh;
      r.set_minute = sm;
      while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      update_clock(r, want);
      expected_displays.push_back(typed ? given : want);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_func(input logic [2:0] f);
      send_event(f, 5'($urandom_range(31, 0)), 6'($urandom_range(63, 0)), 1'b0, PREDICTED);
   endtask

   task automatic go_mode(input acc_pkg::mode_type m);
      while (mode != m) send_func(acc_pkg::FUNC_MENU);
   endtask

   task automatic go_digit(input logic [1:0] d);
      while (digit != d) send_func(acc_pkg::FUNC_SELECT);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_displays.size() != 0);
   endtask

   task automatic flag_error(input string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [6:0] want, input logic [6:0] got);
      if (got !== want) flag_error($sformatf("%s: expected %h, got %h", name, want, got));
   endtask

   always @(posedge clock) begin : check_display
      acc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_displays.size() == 0) begin
            flag_error("response with no request outstanding");
         end else begin
            want = expected_displays.pop_front();
            check_field("seg_hour_tens", want.seg_hour_tens, rsp_data.seg_hour_tens);
            check_field("seg_hour_units", want.seg_hour_units, rsp_data.seg_hour_units);
            check_field("seg_minute_tens", want.seg_minute_tens, rsp_data.seg_minute_tens);
            check_field("seg_minute_units", want.seg_minute_units, rsp_data.seg_minute_units);
            check_field("led_pattern", {1'b0, want.led_pattern},
                        {1'b0, rsp_data.led_pattern});
            check_field("alarm_fire", {6'b0, want.alarm_fire}, {6'b0, rsp_data.alarm_fire});
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int pick;
      int n;
      int target;
      int phase_goal;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      script = '{
         {FUNC_SPARE0, 5'd31, 6'd63, 1'b1, ZERO_DISPLAY},  // unused codes touch nothing
         {FUNC_SPARE1, 5'd0,  6'd0,  1'b1, ZERO_DISPLAY},
         {FUNC_SPARE2, 5'd21, 6'd42, 1'b1, ZERO_DISPLAY},
         // saturates to 23:59, no redraw
         {acc_pkg::FUNC_SERIAL, 5'd31, 6'd63, 1'b1, ZERO_DISPLAY},
         {acc_pkg::FUNC_MENU,   5'd0,  6'd0,  1'b1, ALARM_2359},
         {acc_pkg::FUNC_UP,     5'd10, 6'd21, 1'b0, PREDICTED},
         {acc_pkg::FUNC_SELECT, 5'd0,  6'd0,  1'b0, PREDICTED},
         {acc_pkg::FUNC_UP,     5'd0,  6'd0,  1'b0, PREDICTED},
         {acc_pkg::FUNC_SELECT, 5'd0,  6'd0,  1'b0, PREDICTED},
         {acc_pkg::FUNC_UP,     5'd0,  6'd0,  1'b0, PREDICTED},
         {acc_pkg::FUNC_SELECT, 5'd0,  6'd0,  1'b0, PREDICTED},
         {acc_pkg::FUNC_MENU,   5'd0,  6'd0,  1'b0, PREDICTED},
         {acc_pkg::FUNC_SELECT, 5'd0,  6'd0,  1'b0, PREDICTED},
         {acc_pkg::FUNC_UP,     5'd0,  6'd0,  1'b0, PREDICTED},
         {acc_pkg::FUNC_SELECT, 5'd0,  6'd0,  1'b0, PREDICTED},
         {acc_pkg::FUNC_UP,     5'd0,  6'd0,  1'b0, PREDICTED},
         {acc_pkg::FUNC_TICK,   5'd0,  6'd0,  1'b0, PREDICTED},
         // leaving time edit keeps the digits
         {acc_pkg::FUNC_MENU,   5'd0,  6'd0,  1'b0, PREDICTED},
         {acc_pkg::FUNC_SELECT, 5'd0,  6'd0,  1'b0, PREDICTED},
         {acc_pkg::FUNC_UP,     5'd0,  6'd0,  1'b0, PREDICTED},
         {acc_pkg::FUNC_SERIAL, 5'd0,  6'd0,  1'b0, PREDICTED},
         {acc_pkg::FUNC_SERIAL, 5'd23, 6'd59, 1'b0, PREDICTED},
         {acc_pkg::FUNC_SERIAL, 5'd24, 6'd60, 1'b0, PREDICTED},
         {acc_pkg::FUNC_TICK,   5'd31, 6'd63, 1'b0, PREDICTED}
      };
      foreach (script[i]) begin
         send_event(script[i].func, script[i].set_hour, script[i].set_minute,
                    script[i].typed, script[i].display);
      end

      for (int p = 0; p < 4; p++) begin
         if (p != 0) drain_responses();
         case (p)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 79; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 79; end
            default: begin idle_pct = 21; stall_pct = 21; end
         endcase
         phase_goal = items_sent + PHASE_ITEMS;
         while (items_sent < phase_goal) begin
            pick = $urandom_range(99, 0);
            if (pick < 20) begin
               // ticks, often up to the next rollover with the alarm armed for it
               if ($urandom_range(1, 0)) begin
                  if ($urandom_range(1, 0)) begin
                     target = (clk_hour * 60 + clk_min + 1) % MINUTES_PER_DAY;
                     send_event(acc_pkg::FUNC_SERIAL, 5'(target / 60), 6'(target % 60),
                                1'b0, PREDICTED);
                  end
                  n = 60 - clk_sec;
               end else begin
                  n = $urandom_range(8, 1);
               end
               repeat (n) send_func(acc_pkg::FUNC_TICK);
            end else if (pick < 25) begin
               // set the time to 23:59 by the buttons, then roll over midnight
               go_mode(acc_pkg::MODE_TIME);
               go_digit(acc_pkg::DIGIT_HOUR);
               while (clk_hour != acc_pkg::HOUR_MAX) send_func(acc_pkg::FUNC_UP);
               go_digit(acc_pkg::DIGIT_UNITS);
               while (clk_min % 10 != 9) send_func(acc_pkg::FUNC_UP);
               go_digit(acc_pkg::DIGIT_TENS);
               while (clk_min / 10 != 5) send_func(acc_pkg::FUNC_UP);
               if ($urandom_range(1, 0)) go_mode(acc_pkg::MODE_RUN);
               if ($urandom_range(1, 0))
                  send_event(acc_pkg::FUNC_SERIAL, 5'd0, 6'd0, 1'b0, PREDICTED);
               repeat (60 - clk_sec) send_func(acc_pkg::FUNC_TICK);
            end else if (pick < 80) begin
               if ($urandom_range(9, 0) < 7)
                  go_mode($urandom_range(1, 0) ? acc_pkg::MODE_ALARM : acc_pkg::MODE_TIME);
               repeat ($urandom_range(12, 3)) begin
                  n = $urandom_range(9, 0);
                  if (n < 2) send_func(acc_pkg::FUNC_MENU);
                  else if (n < 4) send_func(acc_pkg::FUNC_SELECT);
                  else if (n < 8) send_func(acc_pkg::FUNC_UP);
                  else if (n < 9) send_func(acc_pkg::FUNC_SERIAL);
                  else send_func(acc_pkg::FUNC_TICK);
               end
            end else begin
               repeat ($urandom_range(3, 1)) send_func(3'($urandom_range(7, 0)));
            end
         end
      end

      drain_responses();
      repeat (8) @(negedge clock);
      errors += expected_displays.size();
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/acc_pkg.sv
rtl/acc_in_stage.sv
rtl/acc_core.sv
rtl/acc_out_stage.sv
rtl/alarm_clock_controller.sv
rtl/acc_checker.sv
sim/alarm_clock_controller_tb.sv
